@@ rtl/core/lpr_pkg.sv @@
// Shared types and constants for the line pixel rasterizer.
package lpr_pkg;

    localparam int COORD_W = 6;
    localparam int SIZE_W  = 7;
    localparam int ERR_W   = 7;
    localparam logic [ERR_W-1:0] ERR_MAX = 7'd127;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        DIR_FLAT = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_UP   = 2'd2
    } t_step_dir;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fin;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/lpr_ctrl.sv @@
// Sequencer for the line pixel rasterizer: accepts a request, then steps pixels.
module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Choose the next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.out_free && i_stat.fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Drive commands and the input stall
    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_RUN: begin
                o_cmd.step = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/core/lpr_datapath.sv @@
// Line stepper datapath: request registers, error accumulator, clipping, output register.
module lpr_datapath
    import lpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_index,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    input  logic [COORD_W-1:0] i_start_x,
    input  logic [COORD_W-1:0] i_start_y,
    input  logic [COORD_W-1:0] i_end_x,
    input  logic [COORD_W-1:0] i_end_y,
    input  logic               i_color,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic               o_pixel_value,
    output logic               o_write_enable,
    output logic               o_last
);

    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;
    logic [COORD_W-1:0] r_cur_x;
    logic [COORD_W-1:0] r_cur_y;
    logic [ERR_W-1:0]   r_err;
    logic [COORD_W-1:0] r_stop_x;
    logic [COORD_W-1:0] r_dx;
    logic [COORD_W-1:0] r_ady;
    t_step_dir          r_dir;
    logic               r_color;
    logic               r_empty;
    logic               r_out_valid;

    logic [COORD_W-1:0] n_cur_y;
    logic [ERR_W-1:0]   n_err;
    logic [ERR_W:0]     err_sum;
    logic [ERR_W:0]     err_sub;
    logic               fin;
    logic               in_bounds;

    // Configuration registers: the user must write them only while idle; not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_RESET;
            r_height <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    // Final pixel of the request and clip test for the current pixel
    assign fin = r_empty ||
                 (({1'b0, r_cur_x} + 7'd1) == {1'b0, r_stop_x});
    assign in_bounds = ({1'b0, r_cur_x} < r_width) && ({1'b0, r_cur_y} < r_height);

    // Accumulate the error, step the row once at most, saturate
    always_comb begin
        err_sum = {1'b0, r_err} + {2'b00, r_ady};
        err_sub = err_sum;
        n_cur_y = r_cur_y;
        if (err_sum >= {2'b00, r_dx}) begin
            err_sub = err_sum - {2'b00, r_dx};
            case (r_dir)
                DIR_DOWN: n_cur_y = r_cur_y + 6'd1;
                DIR_UP:   n_cur_y = r_cur_y - 6'd1;
                default:  n_cur_y = r_cur_y;
            endcase
        end
        if (err_sub > {1'b0, ERR_MAX}) begin
            n_err = ERR_MAX;
        end else begin
            n_err = err_sub[ERR_W-1:0];
        end
    end

    // Load a request or advance one column
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x  <= i_start_x;
            r_cur_y  <= i_start_y;
            r_err    <= '0;
            r_stop_x <= i_end_x;
            r_dx     <= i_end_x - i_start_x;
            r_color  <= i_color;
            r_empty  <= (i_end_x <= i_start_x);
            if (i_end_y > i_start_y) begin
                r_ady <= i_end_y - i_start_y;
                r_dir <= DIR_DOWN;
            end else if (i_end_y < i_start_y) begin
                r_ady <= i_start_y - i_end_y;
                r_dir <= DIR_UP;
            end else begin
                r_ady <= '0;
                r_dir <= DIR_FLAT;
            end
        end else if (i_cmd.step) begin
            r_cur_x <= r_cur_x + 6'd1;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
        end
    end

    // Output register: fill on step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            o_pixel_x      <= r_cur_x;
            o_pixel_y      <= r_cur_y;
            o_pixel_value  <= r_color;
            o_write_enable <= in_bounds && !r_empty;
            o_last         <= fin;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.fin      = fin;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

@@ rtl/core/line_pixel_rasterizer.sv @@
// Line pixel rasterizer top level: controller and stepper datapath.
//
// Input channel: i_in_valid / o_in_stall carries one line request (start
// point, exclusive end column, end row, color). A request is taken only
// while the block is idle; o_in_stall stays high while a line is stepped.
// Output channel: o_out_valid / i_out_stall carries one pixel per item, one
// for each column from start_x up to end_x - 1; o_last marks the final pixel.
// An empty line (end_x not above start_x) gives a single pixel with
// o_write_enable low and o_last high.
// Throughput: one pixel per cycle from the stepper while the receiver does
// not stall; the single error-accumulate-and-step unit sets this rate.
// When the receiver stalls, the output register holds its pixel and the
// stepper waits; the next request may be accepted while the final pixel
// still waits to be taken.
// Configuration: i_cfg_valid / o_cfg_ready writes buffer width (index 0)
// or height (index 1), used for clipping; write only while idle.
// Reset (synchronous, active low) returns to idle, empties the output
// register and sets width and height to 64.
module line_pixel_rasterizer
    import lpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [COORD_W-1:0] i_start_x,
    input  logic [COORD_W-1:0] i_start_y,
    input  logic [COORD_W-1:0] i_end_x,
    input  logic [COORD_W-1:0] i_end_y,
    input  logic               i_color,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic               o_pixel_value,
    output logic               o_write_enable,
    output logic               o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    lpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    lpr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_color        (i_color),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_value  (o_pixel_value),
        .o_write_enable (o_write_enable),
        .o_last         (o_last)
    );

endmodule
